### src/satd_pkg.sv
// ----------------------------------------------------------------------------
// SATD package
// Shared widths, coefficient types and the 4-point Hadamard butterfly.
// ----------------------------------------------------------------------------
package satd_pkg;

    localparam int RowPix   = 8;    // pixels per row transfer
    localparam int PixW     = 8;
    localparam int RowBits  = RowPix * PixW;
    localparam int CoefW    = 11;   // row-transformed difference
    localparam int ColW     = 13;   // column-transformed coefficient
    localparam int AbsW     = 12;   // magnitude of a column coefficient
    localparam int ColSumW  = 14;   // four magnitudes of one column
    localparam int TileSumW = 17;   // all magnitudes of one 8x4 tile
    localparam int TotalW   = 20;
    localparam int CodeW    = 2;
    localparam int TileCntW = 4;
    localparam int TileRows = 4;
    localparam int BufRows  = TileRows - 1;
    localparam int AddrW    = 3;
    localparam int DataW    = 32;
    localparam int InDataW  = 2 * RowBits;
    localparam int OutDataW = 24;

    // size codes
    localparam logic [CodeW-1:0] Code4  = 2'd0;
    localparam logic [CodeW-1:0] Code16 = 2'd2;
    localparam logic [CodeW-1:0] CodeMax = 2'd2;

    // register select (address bit 2)
    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    typedef logic signed [CoefW-1:0] t_coef;

    typedef struct packed {
        logic signed [ColW-1:0] c3;
        logic signed [ColW-1:0] c2;
        logic signed [ColW-1:0] c1;
        logic signed [ColW-1:0] c0;
    } t_h4;

    function automatic t_h4 hadamard4(input logic signed [ColW-1:0] s0,
                                      input logic signed [ColW-1:0] s1,
                                      input logic signed [ColW-1:0] s2,
                                      input logic signed [ColW-1:0] s3);
        logic signed [ColW-1:0] t0;
        logic signed [ColW-1:0] t1;
        logic signed [ColW-1:0] t2;
        logic signed [ColW-1:0] t3;
        t_h4                    o;
        t0 = s0 + s1;
        t1 = s0 - s1;
        t2 = s2 + s3;
        t3 = s2 - s3;
        o.c0 = t0 + t2;
        o.c1 = t1 + t3;
        o.c2 = t0 - t2;
        o.c3 = t1 - t3;
        return o;
    endfunction

endpackage

### src/satd_row_xform.sv
// ----------------------------------------------------------------------------
// SATD row transform
// Pixel differences of one row and a 4-point Hadamard per 4-pixel half.
// ----------------------------------------------------------------------------
module satd_row_xform (
    input  logic [satd_pkg::RowBits-1:0] i_cur,
    input  logic [satd_pkg::RowBits-1:0] i_ref,
    output satd_pkg::t_coef              o_coef [satd_pkg::RowPix]
);
    import satd_pkg::*;

    logic signed [ColW-1:0] d [RowPix];
    t_h4                    h [2];

    always_comb begin
        for (int i = 0; i < RowPix; i++) begin
            d[i] = $signed({{(ColW-PixW){1'b0}}, i_cur[PixW*i +: PixW]})
                 - $signed({{(ColW-PixW){1'b0}}, i_ref[PixW*i +: PixW]});
        end
        for (int k = 0; k < 2; k++) begin
            h[k] = hadamard4(d[4*k], d[4*k+1], d[4*k+2], d[4*k+3]);
            // magnitudes stay below 1024, so the low bits carry the value
            o_coef[4*k]   = h[k].c0[CoefW-1:0];
            o_coef[4*k+1] = h[k].c1[CoefW-1:0];
            o_coef[4*k+2] = h[k].c2[CoefW-1:0];
            o_coef[4*k+3] = h[k].c3[CoefW-1:0];
        end
    end

endmodule

### src/satd_col_sum.sv
// ----------------------------------------------------------------------------
// SATD column sum
// Column Hadamard over four row coefficients and the sum of magnitudes.
// ----------------------------------------------------------------------------
module satd_col_sum (
    input  satd_pkg::t_coef              i_r0,
    input  satd_pkg::t_coef              i_r1,
    input  satd_pkg::t_coef              i_r2,
    input  satd_pkg::t_coef              i_r3,
    output logic [satd_pkg::ColSumW-1:0] o_sum
);
    import satd_pkg::*;

    t_h4                    h;
    logic signed [ColW-1:0] v  [TileRows];
    logic [AbsW-1:0]        mg [TileRows];

    always_comb begin
        h = hadamard4(ColW'(i_r0), ColW'(i_r1), ColW'(i_r2), ColW'(i_r3));
        v[0] = h.c0;
        v[1] = h.c1;
        v[2] = h.c2;
        v[3] = h.c3;
        for (int r = 0; r < TileRows; r++) begin
            mg[r] = v[r][ColW-1] ? AbsW'(-v[r]) : AbsW'(v[r]);
        end
        o_sum = ColSumW'(mg[0]) + ColSumW'(mg[1]) + ColSumW'(mg[2]) + ColSumW'(mg[3]);
    end

endmodule

### src/satd_hadamard_block_unit.sv
// ----------------------------------------------------------------------------
// SATD Hadamard block unit
// Streams pixel rows of a block, transforms 4-row tiles and emits the
// block's sum of absolute transformed differences.
// ----------------------------------------------------------------------------
//  channel   | direction | payload (lowest bit first)
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | cur_row[63:0], ref_row[127:64]
//  m_axis    | out       | satd_total[19:0], zero fill to 24 bits
//  apb       | in/out    | 0x0 width_code, 0x4 height_code (2 bits each)
//
//  One row transfer per cycle, sustained; the pipeline never waits on
//  itself, only on m_axis_tready when a finished total is still held.
//  The total reaches m_axis through the input register, the row coefficient
//  register, the column sum register and the output register.
//  Reset (synchronous, active low) clears the codes, counters and valids.
//  A stalled result backs up through the column stages and then holds the
//  row input, so no row enters the row buffer while a fourth row waits.
// ----------------------------------------------------------------------------
module satd_hadamard_block_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream: cur_row[63:0], ref_row[127:64]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [satd_pkg::InDataW-1:0]     s_axis_tdata,
    // master stream: satd_total[19:0], zeros above
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [satd_pkg::OutDataW-1:0]    m_axis_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [satd_pkg::AddrW-1:0]       paddr,
    input  logic [satd_pkg::DataW-1:0]       pwdata,
    output logic [satd_pkg::DataW-1:0]       prdata,
    output logic                             pready
);
    import satd_pkg::*;

    localparam logic [1:0]          LastRow  = 2'(TileRows - 1);
    localparam logic [TileCntW-1:0] MaxTile  = TileCntW'(7);

    // configuration registers
    logic [CodeW-1:0]    r_width;
    logic [CodeW-1:0]    r_height;
    logic                cfg_wr;
    logic [CodeW-1:0]    wc;
    logic [CodeW-1:0]    hc;
    logic [TileCntW-1:0] tile_cnt;
    logic                last_tile;

    // stage 1: input row
    logic                r_v1;
    logic [RowBits-1:0]  r_cur;
    logic [RowBits-1:0]  r_ref;
    logic [1:0]          r_phase;
    logic [1:0]          n_phase;
    logic [TileCntW-1:0] r_tile;
    logic [TileCntW-1:0] n_tile;
    t_coef               row_coef [RowPix];

    // row buffer and stage 2: fourth row of a tile
    t_coef               r_buf [BufRows][RowPix];
    t_coef               r_rc  [RowPix];
    logic                r_v2;
    logic                r_done2;

    // stage 3: column sums
    logic [ColSumW-1:0]  col_sum [RowPix];
    logic [ColSumW-1:0]  r_csum  [RowPix];
    logic                r_v3;
    logic                r_done3;
    logic [TileSumW-1:0] tile_sum;
    logic [TotalW-1:0]   r_acc;
    logic [TotalW-1:0]   n_acc;

    // output register
    logic                r_out_valid;
    logic [TotalW-1:0]   r_out_data;

    // flow control
    logic out_free;
    logic rel1;
    logic rel2;
    logic rel3;
    logic free2;
    logic free3;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == RegHeight) ? DataW'(r_height) : DataW'(r_width);

    // code three acts as the largest size
    assign wc = (r_width  > CodeMax) ? CodeMax : r_width;
    assign hc = (r_height > CodeMax) ? CodeMax : r_height;
    assign tile_cnt  = ((wc == Code16) ? TileCntW'(2) : TileCntW'(1)) << hc;
    assign last_tile = ((TileCntW+1)'(r_tile) + (TileCntW+1)'(1))
                       >= (TileCntW+1)'(tile_cnt);

    // ---------------------------------------------------------- flow control
    // A stage releases when the next one is empty or releasing too; only
    // tile-complete tokens occupy stages 2 and 3. Stage 1 also waits on
    // stage 2 for every row, since stage 2 reads the row buffer.
    assign out_free = !r_out_valid || m_axis_tready;
    assign rel3     = r_v3 && (!r_done3 || out_free);
    assign free3    = !r_v3 || rel3;
    assign rel2     = r_v2 && free3;
    assign free2    = !r_v2 || rel2;
    assign rel1     = r_v1 && free2;
    assign s_axis_tready = !r_v1 || rel1;

    // ------------------------------------------------------------- datapath
    satd_row_xform u_row (
        .i_cur  (r_cur),
        .i_ref  (r_ref),
        .o_coef (row_coef)
    );

    for (genvar c = 0; c < RowPix; c++) begin : g_col
        satd_col_sum u_col (
            .i_r0  (r_buf[0][c]),
            .i_r1  (r_buf[1][c]),
            .i_r2  (r_buf[2][c]),
            .i_r3  (r_rc[c]),
            .o_sum (col_sum[c])
        );
    end

    always_comb begin
        tile_sum = '0;
        for (int c = 0; c < RowPix; c++) begin
            tile_sum = tile_sum + TileSumW'(r_csum[c]);
        end
        n_acc   = r_acc + TotalW'(tile_sum >> 1);
        n_phase = r_phase + 2'd1;
        n_tile  = last_tile ? '0 : r_tile + TileCntW'(1);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cur <= s_axis_tdata[RowBits-1:0];
            r_ref <= s_axis_tdata[InDataW-1:RowBits];
        end
        if (rel1) begin
            if (r_phase == LastRow) begin
                r_rc    <= row_coef;
                r_done2 <= last_tile;
            end else begin
                r_buf[r_phase] <= row_coef;
            end
        end
        if (rel2) begin
            r_done3 <= r_done2;
            for (int c = 0; c < RowPix; c++) begin
                // a 4-wide block uses only the left half
                r_csum[c] <= (c >= RowPix / 2 && wc == Code4) ? '0 : col_sum[c];
            end
        end
        if (rel3 && r_done3) begin
            r_out_data <= n_acc;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= '0;
            r_height    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_tile      <= '0;
            r_acc       <= '0;
        end else begin
            // stage valids
            if (s_axis_tvalid && s_axis_tready) begin
                r_v1 <= 1'b1;
            end else if (rel1) begin
                r_v1 <= 1'b0;
            end
            if (rel1 && r_phase == LastRow) begin
                r_v2 <= 1'b1;
            end else if (rel2) begin
                r_v2 <= 1'b0;
            end
            if (rel2) begin
                r_v3 <= 1'b1;
            end else if (rel3) begin
                r_v3 <= 1'b0;
            end
            if (rel3 && r_done3) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // row counter advances with each row leaving stage 1, tile counter on each fourth row
            if (rel1) begin
                r_phase <= n_phase;
                if (r_phase == LastRow) begin
                    r_tile <= n_tile;
                end
            end

            // accumulate tiles; drop the sum once the block total is out
            if (rel3) begin
                r_acc <= r_done3 ? '0 : n_acc;
            end

            // a register write abandons any partial block
            if (cfg_wr) begin
                unique case (paddr[2])
                    RegWidth:  r_width  <= pwdata[CodeW-1:0];
                    RegHeight: r_height <= pwdata[CodeW-1:0];
                    default:   ;
                endcase
                r_phase <= '0;
                r_tile  <= '0;
                r_acc   <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutDataW'(r_out_data);

`ifndef SYNTHESIS
    a_tile_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v2) |-> $past(r_v1 && r_phase == LastRow))
        else $error("tile token without a fourth row");

    a_total_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v3 && r_done3))
        else $error("total emitted without a finished block");

    a_tile_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tile <= MaxTile)
        else $error("tile counter beyond the largest block");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !rel1 && !cfg_wr) |=> $stable(r_phase))
        else $error("row phase moved while the row was held");
`endif

endmodule

### bench/tb_satd_hadamard_block_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SATD Hadamard block unit testbench
// Streams pixel rows through the block under every size setting and checks
// each emitted block total against a row-by-row software prediction of the
// tile transforms. Sender bursts, receiver stalls and size reprogramming
// between phases exercise the handshakes and the block bookkeeping.
// ----------------------------------------------------------------------------
module tb_satd_hadamard_block_unit;

    import satd_pkg::*;

    // pixel content styles for generated rows
    typedef enum int {
        PixRandom  = 0,
        PixExtreme = 1,
        PixNear    = 2
    } t_pix_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // cur_row[63:0], ref_row[127:64]
    logic [InDataW-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // satd_total[19:0], zero fill [23:20]
    logic [OutDataW-1:0]  m_axis_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrW-1:0]     paddr = '0;
    logic [DataW-1:0]     pwdata = '0;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    satd_hadamard_block_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow of the block: size codes, tile position, row coefficients and
    // the running total. Updated at the clock edge of each accepted transfer.
    // ------------------------------------------------------------------------
    logic [CodeW-1:0]    width_sel;
    logic [CodeW-1:0]    height_sel;
    logic [1:0]          tile_row;
    logic [TileCntW-1:0] tiles_done;
    int                  row_xform [TileRows][RowPix];
    logic [TotalW-1:0]   running_total;

    logic [TotalW-1:0]   pending_totals [$];
    int                  fail_count = 0;
    int                  rows_sent = 0;

    // sender burst bookkeeping
    int                  burst_left = 0;

    // 4-point butterfly on plain integers
    function automatic void wht4(input int s0, input int s1, input int s2, input int s3,
                                 output int o0, output int o1, output int o2,
                                 output int o3);
        int t0;
        int t1;
        int t2;
        int t3;
        t0 = s0 + s1;
        t1 = s0 - s1;
        t2 = s2 + s3;
        t3 = s2 - s3;
        o0 = t0 + t2;
        o1 = t1 + t3;
        o2 = t0 - t2;
        o3 = t1 - t3;
    endfunction

    // codes of three act as two
    function automatic int clamp_code(input logic [CodeW-1:0] code);
        return (code > CodeMax) ? int'(CodeMax) : int'(code);
    endfunction

    function automatic int tiles_per_block(input logic [CodeW-1:0] wsel,
                                           input logic [CodeW-1:0] hsel);
        return ((clamp_code(wsel) == int'(Code16)) ? 2 : 1) << clamp_code(hsel);
    endfunction

    function automatic void clear_block();
        tile_row      = '0;
        tiles_done    = '0;
        running_total = '0;
    endfunction

    // Row transform of one accepted row; finish the tile after its fourth row
    // and queue the block total after the block's last tile.
    function automatic void predict_row(input logic [63:0] cur, input logic [63:0] rf);
        int halves;
        int tiles;
        int d [4];
        int o [4];
        int tile_sum;
        halves = (clamp_code(width_sel) == int'(Code4)) ? 1 : 2;
        tiles  = tiles_per_block(width_sel, height_sel);
        for (int h = 0; h < halves; h++) begin
            for (int k = 0; k < 4; k++) begin
                d[k] = int'(cur[8*(4*h+k) +: 8]) - int'(rf[8*(4*h+k) +: 8]);
            end
            wht4(d[0], d[1], d[2], d[3], o[0], o[1], o[2], o[3]);
            for (int k = 0; k < 4; k++) begin
                row_xform[tile_row][4*h+k] = o[k];
            end
        end
        if (tile_row != 2'd3) begin
            tile_row = tile_row + 2'd1;
            return;
        end
        tile_row = '0;
        tile_sum = 0;
        for (int c = 0; c < 4 * halves; c++) begin
            wht4(row_xform[0][c], row_xform[1][c], row_xform[2][c], row_xform[3][c],
                 o[0], o[1], o[2], o[3]);
            for (int r = 0; r < 4; r++) begin
                tile_sum += (o[r] < 0) ? -o[r] : o[r];
            end
        end
        running_total = running_total + TotalW'(tile_sum >>> 1);
        if (int'(tiles_done) + 1 >= tiles) begin
            pending_totals.push_back(running_total);
            running_total = '0;
            tiles_done    = '0;
        end else begin
            tiles_done = tiles_done + TileCntW'(1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("satd_hadamard_block_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: pick a stall style for a random stretch of cycles, from
    // always-ready through coin flips to long stalls.
    // ------------------------------------------------------------------------
    int rx_left = 0;
    int rx_style = 0;
    int rx_phase = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(8, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_style)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= (rx_phase % 5) != 0;
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted total with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_totals.size() == 0) begin
                $error("satd_total: no result expected, actual %0d",
                       m_axis_tdata[TotalW-1:0]);
                fail_count++;
            end else begin
                if (m_axis_tdata[TotalW-1:0] !== pending_totals[0]) begin
                    $error("satd_total: expected %0d, actual %0d",
                           pending_totals[0], m_axis_tdata[TotalW-1:0]);
                    fail_count++;
                end
                void'(pending_totals.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------

    // Send one row transfer; start a gap and a new burst when the burst runs out.
    task automatic send_row(input logic [63:0] cur, input logic [63:0] rf);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rf, cur};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_row(cur, rf);
        rows_sent++;
    endtask

    // Stop sending and hold until every predicted total has been received.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_totals.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let the pipeline empty out partial tiles too.
    task automatic settle();
        wait_drained();
        repeat (8) @(posedge i_clk);
    endtask

    // Register write: setup phase, then access phase until pready.
    task automatic cfg_write(input logic sel, input logic [CodeW-1:0] code);
        logic [DataW-1:0] value;
        value = {$urandom} & ~DataW'(3);
        value = value | DataW'(code);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (sel == RegWidth) begin
            width_sel = value[CodeW-1:0];
        end else begin
            height_sel = value[CodeW-1:0];
        end
        clear_block();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic make_rows(input t_pix_style style, output logic [63:0] cur,
                             output logic [63:0] rf);
        cur = {$urandom, $urandom};
        rf  = {$urandom, $urandom};
        case (style)
            PixExtreme: begin
                for (int b = 0; b < RowPix; b++) begin
                    cur[8*b +: 8] = {8{cur[8*b]}};
                    rf[8*b +: 8]  = {8{rf[8*b]}};
                end
            end
            PixNear: begin
                for (int b = 0; b < RowPix; b++) begin
                    rf[8*b +: 8] = cur[8*b +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset sizes give 4x4 blocks; the high bytes are noise and must not count.
    task automatic test_reset_size();
        repeat (4) send_row({$urandom, 32'hFFFF_FFFF}, {$urandom, 32'h0000_0000});
        repeat (4) send_row({$urandom, 32'h0000_0000}, {$urandom, 32'hFFFF_FFFF});
        settle();
    endtask

    // A width code of three saturates to the 16-wide setting, here 4 rows
    // high; checkerboard extremes push the total toward its largest value.
    task automatic test_code_three();
        cfg_write(RegWidth, 2'd3);
        cfg_write(RegHeight, 2'd0);
        for (int i = 0; i < 8; i++) begin
            send_row((i % 2) ? 64'hFF00_FF00_FF00_FF00 : 64'h00FF_00FF_00FF_00FF,
                     (i % 2) ? 64'h00FF_00FF_00FF_00FF : 64'hFF00_FF00_FF00_FF00);
        end
        settle();
    endtask

    // A size write in the middle of a block drops the partial block.
    task automatic test_abandon_block();
        logic [63:0] cur;
        logic [63:0] rf;
        cfg_write(RegWidth, 2'd1);
        cfg_write(RegHeight, 2'd1);
        repeat (5) begin
            make_rows(PixRandom, cur, rf);
            send_row(cur, rf);
        end
        settle();
        cfg_write(RegHeight, 2'd0);
        repeat (4) begin
            make_rows(PixExtreme, cur, rf);
            send_row(cur, rf);
        end
        settle();
    endtask

    // Random phases of size settings, mostly small blocks, whole blocks with
    // random content and the odd broken block before a reprogram.
    task automatic test_random_blocks();
        logic [63:0]      cur;
        logic [63:0]      rf;
        logic [CodeW-1:0] wsel;
        logic [CodeW-1:0] hsel;
        int               block_rows;
        int               blocks;
        int               phase_idx;
        t_pix_style       style;
        phase_idx = 0;
        while (rows_sent < 525) begin
            // first two phases hit the smallest and the largest setting
            if (phase_idx == 0) begin
                wsel = 2'd0;
                hsel = 2'd0;
            end else if (phase_idx == 1) begin
                wsel = 2'd2;
                hsel = 2'd2;
            end else begin
                wsel = CodeW'($urandom_range(0, 3));
                hsel = ($urandom_range(0, 9) < 7) ? CodeW'($urandom_range(0, 1)) :
                                                    CodeW'($urandom_range(2, 3));
            end
            settle();
            cfg_write(RegWidth, wsel);
            cfg_write(RegHeight, hsel);
            block_rows = 4 * tiles_per_block(wsel, hsel);
            blocks     = (block_rows >= 32) ? 1 : $urandom_range(1, 4);
            for (int b = 0; b < blocks; b++) begin
                style = t_pix_style'($urandom_range(0, 2));
                for (int r = 0; r < block_rows; r++) begin
                    make_rows(style, cur, rf);
                    send_row(cur, rf);
                end
                // hold off now and then until all totals are back
                if (b == 0 || $urandom_range(0, 3) == 0) begin
                    wait_drained();
                end
            end
            // broken block: a few rows left behind for the next reprogram
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, block_rows - 1)) begin
                    make_rows(PixRandom, cur, rf);
                    send_row(cur, rf);
                end
            end
            phase_idx++;
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        width_sel  = '0;
        height_sel = '0;
        clear_block();
        for (int r = 0; r < TileRows; r++) begin
            for (int c = 0; c < RowPix; c++) begin
                row_xform[r][c] = 0;
            end
        end
        // hold reset, then release
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_code_three();
        test_abandon_block();
        test_random_blocks();

        // drop valid and let the pipeline go quiet before judging
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("satd_hadamard_block_unit test passed");
        end else begin
            $display("satd_hadamard_block_unit test failed");
        end
        $finish;
    end

endmodule
